// ===== hdl/two_level_local_branch_predictor_defines.svh =====
// Assertion macros used by the predictor RTL.
`ifndef TWO_LEVEL_LOCAL_BRANCH_PREDICTOR_DEFINES_SVH
`define TWO_LEVEL_LOCAL_BRANCH_PREDICTOR_DEFINES_SVH

`ifndef ASSERT_OFF

// Check that a consequent holds in the same cycle as its antecedent
`define LBP_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("lbp assertion failed");

// Check that a consequent holds in the cycle after its antecedent
`define LBP_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("lbp assertion failed");

`else

`define LBP_ASSERT_IMP(label, clk, rstn, ante, cons)
`define LBP_ASSERT_NXT(label, clk, rstn, ante, cons)

`endif

`endif

// ===== hdl/lbp_pkg.sv =====
`default_nettype none

package lbp_pkg;

    // Transaction opcodes
    typedef enum logic [0:0] {
        OP_PREDICT = 1'b0,
        OP_UPDATE  = 1'b1
    } opcode_t;

    typedef logic [1:0] ctr_t;

    // Counter value after reset: weakly not taken
    localparam ctr_t CTR_INIT   = 2'd1;
    localparam ctr_t CTR_MAX    = 2'd3;
    localparam ctr_t CTR_MIN    = 2'd0;

    // Train a 2-bit counter: snap to the rail on a correct guess, else step toward outcome
    function automatic ctr_t ctr_train(input ctr_t ctr, input logic guess, input logic taken);
        ctr_t res;
        if (taken) begin
            if (guess) begin
                res = CTR_MAX;
            end else begin
                res = (ctr == CTR_MAX) ? CTR_MAX : ctr_t'(ctr + 2'd1);
            end
        end else begin
            if (guess) begin
                res = (ctr == CTR_MIN) ? CTR_MIN : ctr_t'(ctr - 2'd1);
            end else begin
                res = CTR_MIN;
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/two_level_local_branch_predictor.sv =====
// Channel | Direction | Handshake          | Payload
// s_      | in        | s_valid / s_ready  | s_opcode, s_branch_address,
//         |           |                    | s_predicted_taken, s_actual_taken
// m_      | out       | m_valid / m_ready  | m_prediction_taken
//
// Each transaction runs a history read, then a counter read, then a final step
// that writes both tables back (update) or loads the result register (predict).
// After reset a clearing pass steps through every address of the larger table
// and writes both tables; s_ready stays low during it.
// A predict transaction waits in its last cycle while the result register is full
// and not being taken; a waiting result does not block a new input transaction.
`default_nettype none

`include "two_level_local_branch_predictor_defines.svh"

module two_level_local_branch_predictor #(
    parameter int LOG_HISTORY_ENTRIES = 10,
    parameter int LOG_COUNTER_ENTRIES = 12
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic                   s_opcode,
    input  wire logic [31:0]            s_branch_address,
    input  wire logic                   s_predicted_taken,
    input  wire logic                   s_actual_taken,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic                        m_prediction_taken
);

    import lbp_pkg::*;

    localparam int LH    = LOG_HISTORY_ENTRIES;
    localparam int LC    = LOG_COUNTER_ENTRIES;
    localparam int CLR_W = (LH > LC) ? LH : LC;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HWAIT,
        ST_CWAIT
    } state_t;

    state_t            state_reg;
    logic [CLR_W-1:0]  clr_reg;
    opcode_t           op_reg;
    logic [LH-1:0]     slot_reg;
    logic              pred_reg;
    logic              act_reg;
    logic              m_valid_reg;
    logic              m_pred_reg;

    logic              accept;
    logic              clearing;
    logic              out_free;
    logic              finish;
    logic              do_update;
    logic              m_load;

    logic              hist_we;
    logic [LH-1:0]     hist_waddr;
    logic [LC-1:0]     hist_wdata;
    logic              hist_re;
    logic [LC-1:0]     hist_rdata;
    logic [LC:0]       hist_shift;

    logic              ctr_we;
    logic [LC-1:0]     ctr_waddr;
    ctr_t              ctr_wdata;
    logic              ctr_re;
    ctr_t              ctr_rdata;
    ctr_t              ctr_trained;

    // Handshake and sequencing control
    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign clearing  = (state_reg == ST_CLEAR);
    assign out_free  = !m_valid_reg || m_ready;
    assign finish    = (state_reg == ST_CWAIT) && ((op_reg == OP_UPDATE) || out_free);
    assign do_update = finish && (op_reg == OP_UPDATE);
    assign m_load    = finish && (op_reg == OP_PREDICT);

    // History table: read on accept, write back on update or during clear
    assign hist_re    = accept;
    assign hist_shift = {hist_rdata, act_reg};
    assign hist_we    = clearing || do_update;
    assign hist_waddr = clearing ? clr_reg[LH-1:0] : slot_reg;
    assign hist_wdata = clearing ? '0 : hist_shift[LC-1:0];

    // Counter table: read with the history pattern, write the trained counter
    assign ctr_re      = (state_reg == ST_HWAIT);
    assign ctr_trained = ctr_train(ctr_rdata, pred_reg, act_reg);
    assign ctr_we      = clearing || do_update;
    assign ctr_waddr   = clearing ? clr_reg[LC-1:0] : hist_rdata;
    assign ctr_wdata   = clearing ? CTR_INIT : ctr_trained;

    lbp_ram #(
        .ADDR_W (LH),
        .DATA_W (LC)
    ) u_hist_ram (
        .aclk  (aclk),
        .we    (hist_we),
        .waddr (hist_waddr),
        .wdata (hist_wdata),
        .re    (hist_re),
        .raddr (s_branch_address[LH:1]),
        .rdata (hist_rdata)
    );

    lbp_ram #(
        .ADDR_W (LC),
        .DATA_W (2)
    ) u_ctr_ram (
        .aclk  (aclk),
        .we    (ctr_we),
        .waddr (ctr_waddr),
        .wdata (ctr_wdata),
        .re    (ctr_re),
        .raddr (hist_rdata),
        .rdata (ctr_rdata)
    );

    // Sequencer, transaction capture and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            // Load a new result, or drop the one the receiver took
            if (m_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_CLEAR: begin
                    clr_reg <= clr_reg + 1'b1;
                    if (&clr_reg) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (accept) begin
                        op_reg    <= opcode_t'(s_opcode);
                        slot_reg  <= s_branch_address[LH:1];
                        pred_reg  <= s_predicted_taken;
                        act_reg   <= s_actual_taken;
                        state_reg <= ST_HWAIT;
                    end
                end
                ST_HWAIT: begin
                    state_reg <= ST_CWAIT;
                end
                ST_CWAIT: begin
                    if (finish) begin
                        if (m_load) begin
                            m_pred_reg <= ctr_rdata[1];
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_prediction_taken = m_pred_reg;

    // A new result only ever comes from a predict transaction
    `LBP_ASSERT_IMP(a_result_from_predict, aclk, aresetn, $rose(m_valid_reg), $past(op_reg == OP_PREDICT))
    // Table writes never overlap a history read of the next transaction
    `LBP_ASSERT_IMP(a_no_rw_overlap, aclk, aresetn, hist_we || ctr_we, !hist_re && !ctr_re)
    // An accepted transaction always goes on to the counter read
    `LBP_ASSERT_NXT(a_accept_to_read, aclk, aresetn, accept, ctr_re && !s_ready)

endmodule

`default_nettype wire

// ===== hdl/lbp_ram.sv =====
`default_nettype none

module lbp_ram #(
    parameter int ADDR_W = 10,
    parameter int DATA_W = 12
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port; hold data while not enabled
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire
